### design/tqc_pkg.sv
package tqc_pkg;

    localparam int COORD_WIDTH     = 16;
    localparam int GRADE_FRAC_BITS = 16;
    localparam int NORM_BITS       = 24;
    localparam int LEN_FRAC        = 8;
    localparam int RATIO_FRAC      = 24;
    localparam int ROOT_BITS       = (NORM_BITS + 2 * LEN_FRAC) / 2;
    localparam int QUOT_BITS       = 27;
    localparam int PROD_SHIFT      = 2 * RATIO_FRAC - GRADE_FRAC_BITS - 1;
    localparam int IN_BEAT_BITS    = 8 * COORD_WIDTH;
    localparam int OUT_BEAT_BITS   = 24;

    localparam int SQ_FIRST  = 5;
    localparam int DIV_FIRST = SQ_FIRST + ROOT_BITS + 2;
    localparam int LAST_STG  = DIV_FIRST + QUOT_BITS + 1;

    typedef logic signed [COORD_WIDTH:0]       diff_t;
    typedef logic signed [2*COORD_WIDTH+1:0]   prod_t;
    typedef logic signed [2*COORD_WIDTH+2:0]   cross_t;
    typedef logic [2*COORD_WIDTH+1:0]          sqlen_t;
    typedef logic [NORM_BITS-1:0]              norm_t;
    typedef logic [ROOT_BITS-1:0]              root_t;

    typedef struct packed {
        logic degen;
        logic contained;
        logic zero;
    } flags_t;

endpackage

### design/triangle_quality_and_containment_unit.sv
// channel | group    | direction | tdata fields, lowest bit up
// input   | s_axis_* | in        | vert0_x vert0_y vert1_x vert1_y vert2_x vert2_y query_x query_y
// output  | m_axis_* | out       | quality[15:0] degenerate[16] inside_res[17], zero pad to 24
// one triangle a cycle while the skid is empty; an accepted beat passes these stages to the output register:
// differences, products, sums, normalize (2), root (20 steps, one bit each),
// length products (3), two quotients (27 steps, one bit each), grade product
// the whole pipeline moves together; a two-entry output register and skid
// keep input open while one result waits
// reset clears only the valid bits and the output registers
module triangle_quality_and_containment_unit
    import tqc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [IN_BEAT_BITS-1:0]  s_axis_tdata,  // vert0_x vert0_y vert1_x vert1_y vert2_x vert2_y query_x query_y
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [OUT_BEAT_BITS-1:0] m_axis_tdata   // quality degenerate inside_res pad
);

    localparam logic [QUOT_BITS-1:0] CLAMP = QUOT_BITS'(1) << (QUOT_BITS - 1);

    logic adv;
    logic vld_reg [0:LAST_STG];
    flags_t flg_reg [2:LAST_STG];

    // stage 0
    diff_t e0x_reg, e0y_reg, e1x_reg, e1y_reg, e2x_reg, e2y_reg;
    diff_t q0x_reg, q0y_reg, q1x_reg, q1y_reg, q2x_reg, q2y_reg;
    // stage 1
    prod_t s0x_reg, s0y_reg, s1x_reg, s1y_reg, s2x_reg, s2y_reg;
    prod_t ca_reg, cb_reg, k0a_reg, k0b_reg, k1a_reg, k1b_reg, k2a_reg, k2b_reg;
    // stage 2
    sqlen_t da_reg, db_reg, dc_reg, c_reg;
    // stage 3
    sqlen_t mx_reg, da3_reg, db3_reg, dc3_reg, c3_reg;
    // stage 4
    norm_t da4_reg, db4_reg, dc4_reg, c4_reg;
    // root steps
    logic [NORM_BITS+2*LEN_FRAC+1:0] sq_rem_reg [0:ROOT_BITS-1][0:2];
    root_t sq_root_reg [0:ROOT_BITS-1][0:2];
    norm_t sq_c_reg [0:ROOT_BITS-1];
    // lengths
    root_t la_reg, lb_reg, lc_reg;
    logic [ROOT_BITS+1:0] p_reg;
    norm_t c25_reg, c26_reg;
    logic [2*ROOT_BITS-1:0] den1_reg;
    logic [2*ROOT_BITS+1:0] den2_reg;
    // quotient steps, index 0 is the precheck
    logic [63:0] dv_rem_reg [0:QUOT_BITS][0:1];
    logic [2*ROOT_BITS+1:0] dv_den_reg [0:QUOT_BITS][0:1];
    logic [QUOT_BITS-1:0] dv_q_reg [0:QUOT_BITS][0:1];
    logic dv_sat_reg [0:QUOT_BITS][0:1];
    // grade
    logic [2*QUOT_BITS-1:0] prod_reg;

    logic out_vld_reg, skid_vld_reg;
    logic [OUT_BEAT_BITS-1:0] out_reg, skid_reg;
    logic [OUT_BEAT_BITS-1:0] beat_next;

    assign adv = !skid_vld_reg;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= LAST_STG; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= s_axis_tvalid;
            for (int k = 1; k <= LAST_STG; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // differences
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            diff_t x0, y0, x1, y1, x2, y2, qx, qy;
            x0 = diff_t'($signed(s_axis_tdata[0*COORD_WIDTH +: COORD_WIDTH]));
            y0 = diff_t'($signed(s_axis_tdata[1*COORD_WIDTH +: COORD_WIDTH]));
            x1 = diff_t'($signed(s_axis_tdata[2*COORD_WIDTH +: COORD_WIDTH]));
            y1 = diff_t'($signed(s_axis_tdata[3*COORD_WIDTH +: COORD_WIDTH]));
            x2 = diff_t'($signed(s_axis_tdata[4*COORD_WIDTH +: COORD_WIDTH]));
            y2 = diff_t'($signed(s_axis_tdata[5*COORD_WIDTH +: COORD_WIDTH]));
            qx = diff_t'($signed(s_axis_tdata[6*COORD_WIDTH +: COORD_WIDTH]));
            qy = diff_t'($signed(s_axis_tdata[7*COORD_WIDTH +: COORD_WIDTH]));
            e0x_reg <= x1 - x0;
            e0y_reg <= y1 - y0;
            e1x_reg <= x2 - x1;
            e1y_reg <= y2 - y1;
            e2x_reg <= x0 - x2;
            e2y_reg <= y0 - y2;
            q0x_reg <= qx - x0;
            q0y_reg <= qy - y0;
            q1x_reg <= qx - x1;
            q1y_reg <= qy - y1;
            q2x_reg <= qx - x2;
            q2y_reg <= qy - y2;
        end
    end

    // products
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0x_reg <= prod_t'(e0x_reg) * prod_t'(e0x_reg);
            s0y_reg <= prod_t'(e0y_reg) * prod_t'(e0y_reg);
            s1x_reg <= prod_t'(e1x_reg) * prod_t'(e1x_reg);
            s1y_reg <= prod_t'(e1y_reg) * prod_t'(e1y_reg);
            s2x_reg <= prod_t'(e2x_reg) * prod_t'(e2x_reg);
            s2y_reg <= prod_t'(e2y_reg) * prod_t'(e2y_reg);
            ca_reg  <= prod_t'(e0y_reg) * prod_t'(e2x_reg);
            cb_reg  <= prod_t'(e0x_reg) * prod_t'(e2y_reg);
            k0a_reg <= prod_t'(e0x_reg) * prod_t'(q0y_reg);
            k0b_reg <= prod_t'(e0y_reg) * prod_t'(q0x_reg);
            k1a_reg <= prod_t'(e1x_reg) * prod_t'(q1y_reg);
            k1b_reg <= prod_t'(e1y_reg) * prod_t'(q1x_reg);
            k2a_reg <= prod_t'(e2x_reg) * prod_t'(q2y_reg);
            k2b_reg <= prod_t'(e2y_reg) * prod_t'(q2x_reg);
        end
    end

    // sums, area, containment
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cross_t cr, k0, k1, k2;
            cr = cross_t'(ca_reg) - cross_t'(cb_reg);
            k0 = cross_t'(k0a_reg) - cross_t'(k0b_reg);
            k1 = cross_t'(k1a_reg) - cross_t'(k1b_reg);
            k2 = cross_t'(k2a_reg) - cross_t'(k2b_reg);
            da_reg <= sqlen_t'(s0x_reg) + sqlen_t'(s0y_reg);
            db_reg <= sqlen_t'(s1x_reg) + sqlen_t'(s1y_reg);
            dc_reg <= sqlen_t'(s2x_reg) + sqlen_t'(s2y_reg);
            c_reg  <= cr[$bits(cross_t)-1] ? sqlen_t'(-cr) : sqlen_t'(cr);
            flg_reg[2].degen     <= (cr == '0);
            flg_reg[2].contained <= k0[$bits(cross_t)-1] && k1[$bits(cross_t)-1]
                                    && k2[$bits(cross_t)-1];
            flg_reg[2].zero      <= 1'b0;
        end
    end

    // largest square
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sqlen_t m;
            m = (da_reg > db_reg) ? da_reg : db_reg;
            mx_reg  <= (dc_reg > m) ? dc_reg : m;
            da3_reg <= da_reg;
            db3_reg <= db_reg;
            dc3_reg <= dc_reg;
            c3_reg  <= c_reg;
            flg_reg[3] <= flg_reg[2];
        end
    end

    // normalize by an even shift
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            int unsigned sh;
            sh = 0;
            for (int b = NORM_BITS; b < $bits(sqlen_t); b += 2)
            begin
                if (mx_reg >> b != '0)
                begin
                    sh = b - NORM_BITS + 2;
                end
            end
            da4_reg <= norm_t'(da3_reg >> sh);
            db4_reg <= norm_t'(db3_reg >> sh);
            dc4_reg <= norm_t'(dc3_reg >> sh);
            c4_reg  <= norm_t'(c3_reg >> sh);
            flg_reg[4] <= flg_reg[3];
        end
    end

    // root, one bit per stage
    for (genvar j = 0; j < ROOT_BITS; j++)
    begin : g_sq
        localparam int B = ROOT_BITS - 1 - j;
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                logic [NORM_BITS+2*LEN_FRAC+1:0] rem, trial;
                root_t root;
                norm_t d [0:2];
                d[0] = da4_reg;
                d[1] = db4_reg;
                d[2] = dc4_reg;
                for (int l = 0; l < 3; l++)
                begin
                    if (j == 0)
                    begin
                        rem  = {2'b00, d[l], (2*LEN_FRAC)'(0)};
                        root = '0;
                    end
                    else
                    begin
                        rem  = sq_rem_reg[(j == 0) ? 0 : j-1][l];
                        root = sq_root_reg[(j == 0) ? 0 : j-1][l];
                    end
                    trial = (($bits(rem))'(root) << 1) + (($bits(rem))'(1) << B);
                    trial = trial << B;
                    if (rem >= trial)
                    begin
                        rem  = rem - trial;
                        root = root | (root_t'(1) << B);
                    end
                    sq_rem_reg[j][l]  <= rem;
                    sq_root_reg[j][l] <= root;
                end
                sq_c_reg[j] <= (j == 0) ? c4_reg : sq_c_reg[(j == 0) ? 0 : j-1];
                flg_reg[SQ_FIRST+j] <= flg_reg[SQ_FIRST+j-1];
            end
        end
    end

    // perimeter and vanished side
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            root_t a, b, c;
            a = sq_root_reg[ROOT_BITS-1][0];
            b = sq_root_reg[ROOT_BITS-1][1];
            c = sq_root_reg[ROOT_BITS-1][2];
            la_reg  <= a;
            lb_reg  <= b;
            lc_reg  <= c;
            p_reg   <= ($bits(p_reg))'(a) + ($bits(p_reg))'(b) + ($bits(p_reg))'(c);
            c25_reg <= sq_c_reg[ROOT_BITS-1];
            flg_reg[SQ_FIRST+ROOT_BITS].degen     <= flg_reg[SQ_FIRST+ROOT_BITS-1].degen;
            flg_reg[SQ_FIRST+ROOT_BITS].contained <= flg_reg[SQ_FIRST+ROOT_BITS-1].contained;
            flg_reg[SQ_FIRST+ROOT_BITS].zero      <= (a == '0) || (b == '0) || (c == '0);
        end
    end

    // denominators
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            den1_reg <= ($bits(den1_reg))'(la_reg) * ($bits(den1_reg))'(lb_reg);
            den2_reg <= ($bits(den2_reg))'(lc_reg) * p_reg;
            c26_reg  <= c25_reg;
            flg_reg[SQ_FIRST+ROOT_BITS+1] <= flg_reg[SQ_FIRST+ROOT_BITS];
        end
    end

    // quotient precheck against the clamp range
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            logic [63:0] num;
            logic [69:0] lim1, lim2;
            num  = {c26_reg, (64 - NORM_BITS)'(0)};
            lim1 = 70'(den1_reg) << QUOT_BITS;
            lim2 = 70'(den2_reg) << QUOT_BITS;
            dv_rem_reg[0][0] <= num;
            dv_rem_reg[0][1] <= num;
            dv_den_reg[0][0] <= ($bits(den2_reg))'(den1_reg);
            dv_den_reg[0][1] <= den2_reg;
            dv_q_reg[0][0]   <= '0;
            dv_q_reg[0][1]   <= '0;
            dv_sat_reg[0][0] <= (70'(num) >= lim1);
            dv_sat_reg[0][1] <= (70'(num) >= lim2);
            flg_reg[DIV_FIRST] <= flg_reg[DIV_FIRST-1];
        end
    end

    // quotient, one bit per stage
    for (genvar j = 1; j <= QUOT_BITS; j++)
    begin : g_dv
        localparam int B = QUOT_BITS - j;
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                logic [69:0] dsh;
                for (int l = 0; l < 2; l++)
                begin
                    dsh = 70'(dv_den_reg[j-1][l]) << B;
                    if (70'(dv_rem_reg[j-1][l]) >= dsh)
                    begin
                        dv_rem_reg[j][l] <= dv_rem_reg[j-1][l] - 64'(dsh);
                        dv_q_reg[j][l]   <= dv_q_reg[j-1][l] | (QUOT_BITS'(1) << B);
                    end
                    else
                    begin
                        dv_rem_reg[j][l] <= dv_rem_reg[j-1][l];
                        dv_q_reg[j][l]   <= dv_q_reg[j-1][l];
                    end
                    dv_den_reg[j][l] <= dv_den_reg[j-1][l];
                    dv_sat_reg[j][l] <= dv_sat_reg[j-1][l];
                end
                flg_reg[DIV_FIRST+j] <= flg_reg[DIV_FIRST+j-1];
            end
        end
    end

    // clamp and grade product
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            logic [QUOT_BITS-1:0] r [0:1];
            for (int l = 0; l < 2; l++)
            begin
                if (dv_sat_reg[QUOT_BITS][l] || dv_q_reg[QUOT_BITS][l] > CLAMP)
                begin
                    r[l] = CLAMP;
                end
                else
                begin
                    r[l] = dv_q_reg[QUOT_BITS][l];
                end
            end
            prod_reg <= ($bits(prod_reg))'(r[0]) * ($bits(prod_reg))'(r[1]);
            flg_reg[LAST_STG] <= flg_reg[LAST_STG-1];
        end
    end

    always_comb
    begin
        logic [2*QUOT_BITS-1:0] g;
        logic [15:0] q;
        g = prod_reg >> PROD_SHIFT;
        q = (g > ($bits(g))'(16'hFFFF)) ? 16'hFFFF : g[15:0];
        if (flg_reg[LAST_STG].degen || flg_reg[LAST_STG].zero)
        begin
            q = '0;
        end
        beat_next = {6'b0, flg_reg[LAST_STG].contained, flg_reg[LAST_STG].degen, q};
    end

    // output register and skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
            out_reg      <= '0;
            skid_reg     <= '0;
        end
        else if (out_vld_reg && !m_axis_tready)
        begin
            if (adv && vld_reg[LAST_STG])
            begin
                skid_reg     <= beat_next;
                skid_vld_reg <= 1'b1;
            end
        end
        else if (skid_vld_reg)
        begin
            out_reg      <= skid_reg;
            out_vld_reg  <= 1'b1;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            out_reg     <= beat_next;
            out_vld_reg <= vld_reg[LAST_STG];
        end
    end

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> vld_reg[0])
        else $error("accepted beat not captured");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[16] |-> m_axis_tdata[15:0] == 16'h0000)
        else $error("degenerate triangle with nonzero grade");

    a_skid_only_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid holds a beat while output empty");

    a_collinear_outside: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[16] |-> !m_axis_tdata[17])
        else $error("collinear triangle contains a point");

endmodule
